[rtl/core/des_pkg.sv]
// shared types and constants for the directory entry sorter
// used by des_prep, des_cell and directory_entry_sorter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int NAME_BYTES   = 24;

    // stream payload widths, padded to whole bytes
    localparam int DATA_BITS = 1 + 8 + 32 + 3 * 64;
    localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;
    localparam int USER_W    = 2;

    localparam logic [63:0] NAME_DOT    = 64'h2E00_0000_0000_0000;
    localparam logic [63:0] NAME_DOTDOT = 64'h2E2E_0000_0000_0000;

    typedef struct packed {
        logic        is_dir;
        logic [7:0]  kind;
        logic [31:0] size;
        logic [63:0] name_w0;
        logic [63:0] name_w1;
        logic [63:0] name_w2;
    } entry_t;

    // what a cell tells its right-hand neighbor
    typedef struct packed {
        logic valid;
        logic ahead;
    } link_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

[rtl/core/des_prep.sv]
// input conditioning: name cut at the first nul and the drop test
// depends on des_pkg
`timescale 1ns / 1ps
`default_nettype none

module des_prep
    import des_pkg::*;
(
    input  wire logic        is_directory,
    input  wire logic [7:0]  kind_code,
    input  wire logic [31:0] file_size,
    input  wire logic [63:0] name_word0,
    input  wire logic [63:0] name_word1,
    input  wire logic [63:0] name_word2,
    output entry_t           entry,
    output logic             keep
);

    logic [NAME_BYTES*8-1:0] raw_name;
    logic [NAME_BYTES*8-1:0] cut_name;

    assign raw_name = {name_word0, name_word1, name_word2};

    // byte 0 sits in the top bits; once a nul is seen all later bytes are zero
    always_comb
    begin
        logic seen;
        logic [7:0] b;
        seen     = 1'b0;
        cut_name = '0;
        for (int k = 0; k < NAME_BYTES; k++)
        begin
            b = raw_name[(NAME_BYTES-1-k)*8 +: 8];
            if (b == 8'h00)
            begin
                seen = 1'b1;
            end
            if (!seen)
            begin
                cut_name[(NAME_BYTES-1-k)*8 +: 8] = b;
            end
        end
    end

    always_comb
    begin
        entry.is_dir  = is_directory;
        entry.kind    = kind_code;
        entry.size    = file_size;
        entry.name_w0 = cut_name[191:128];
        entry.name_w1 = cut_name[127:64];
        entry.name_w2 = cut_name[63:0];
    end

    // empty, "." and ".." are never kept
    assign keep = !((entry.name_w0 == 64'd0) ||
                    (entry.name_w0 == NAME_DOT && entry.name_w1 == 64'd0 &&
                     entry.name_w2 == 64'd0) ||
                    (entry.name_w0 == NAME_DOTDOT && entry.name_w1 == 64'd0 &&
                     entry.name_w2 == 64'd0));

endmodule

`default_nettype wire

[rtl/core/des_cell.sv]
// one slot of the insertion chain: holds an entry, compares it with the
// broadcast candidate and shifts right on insert or left on drain; uses des_pkg
`timescale 1ns / 1ps
`default_nettype none

module des_cell
    import des_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   ins,
    input  wire logic   shl,
    input  wire logic   valid,
    input  wire link_t  prev_link,
    input  wire entry_t new_entry,
    input  wire entry_t left_entry,
    input  wire entry_t right_entry,
    output entry_t      entry,
    output link_t       link
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   ahead;

    // candidate sorts strictly ahead of this slot: directories first, then name
    assign ahead = (new_entry.is_dir != entry_reg.is_dir) ? new_entry.is_dir :
                   ({new_entry.name_w0, new_entry.name_w1, new_entry.name_w2} <
                    {entry_reg.name_w0, entry_reg.name_w1, entry_reg.name_w2});

    assign link.valid = valid;
    assign link.ahead = ahead;
    assign entry      = entry_reg;

    always_comb
    begin
        priority if (shl)
        begin
            entry_next = right_entry;
        end
        else if (ins && prev_link.valid && prev_link.ahead)
        begin
            entry_next = left_entry;
        end
        else if (ins && prev_link.valid && (!valid || ahead))
        begin
            entry_next = new_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

[rtl/core/directory_entry_sorter.sv]
// Directory entry sorter. Entries stream in one per cycle on s_axis and are
// placed by a row of CAPACITY cells that each compare the candidate with their
// own entry and shift right to open a slot, so every cycle both accepts an entry
// and completes the previous insertion (one register stage conditions the name
// first). The transaction marked tlast ends the listing: once it has passed the
// register stage and the state has turned to drain, the sorted list drains from
// the head cell, one transaction per cycle as m_axis takes it, or a single empty
// marker is sent. No entry is accepted from the cycle after the last entry until
// the final result is taken.
// depends on des_pkg, des_prep and des_cell
`timescale 1ns / 1ps
`default_nettype none

module directory_entry_sorter
    import des_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // is_directory, kind_code[7:0], file_size[31:0], name_word0, name_word1,
    // name_word2 (64 each), zero pad
    input  wire logic [DATA_W-1:0] s_axis_tdata,
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // out_is_directory, out_kind_code[7:0], out_file_size[31:0],
    // out_name_word0, out_name_word1, out_name_word2 (64 each), zero pad
    output logic [DATA_W-1:0]      m_axis_tdata,
    // no_entries, truncated
    output logic [USER_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic   p_vld_reg;
    logic   p_keep_reg;
    logic   p_last_reg;
    entry_t p_entry_reg;

    entry_t prep_entry;
    logic   prep_keep;
    logic   s_accept;
    logic   m_accept;
    logic   full;
    logic   ins;
    logic   shl;
    logic   final_out;

    entry_t cell_q [CAPACITY];
    link_t  cell_link [CAPACITY];

    des_prep u_prep (
        .is_directory (s_axis_tdata[0]),
        .kind_code    (s_axis_tdata[8:1]),
        .file_size    (s_axis_tdata[40:9]),
        .name_word0   (s_axis_tdata[104:41]),
        .name_word1   (s_axis_tdata[168:105]),
        .name_word2   (s_axis_tdata[232:169]),
        .entry        (prep_entry),
        .keep         (prep_keep)
    );

    assign s_axis_tready = (state_reg == ST_LOAD) && !(p_vld_reg && p_last_reg);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_accept      = m_axis_tvalid && m_axis_tready;
    assign full          = (cnt_reg == CNT_W'(CAPACITY));
    assign ins           = p_vld_reg && p_keep_reg && !full;
    assign shl           = m_accept && (cnt_reg != '0);
    assign final_out     = (cnt_reg <= CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= s_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            p_entry_reg <= prep_entry;
            p_keep_reg  <= prep_keep;
            p_last_reg  <= s_axis_tlast;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            link_t  prev_link;
            entry_t left_e;
            entry_t right_e;
            logic   valid;

            assign valid = (cnt_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign prev_link.valid = 1'b1;
                assign prev_link.ahead = 1'b0;
                assign left_e          = p_entry_reg;
            end
            else
            begin : g_body
                assign prev_link = cell_link[i-1];
                assign left_e    = cell_q[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign right_e = cell_q[i];
            end
            else
            begin : g_inner
                assign right_e = cell_q[i+1];
            end

            des_cell u_cell (
                .clk         (clk),
                .ins         (ins),
                .shl         (shl),
                .valid       (valid),
                .prev_link   (prev_link),
                .new_entry   (p_entry_reg),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_q[i]),
                .link        (cell_link[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (p_vld_reg && p_last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (m_accept && final_out)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (ins)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (shl)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        if (p_vld_reg && p_keep_reg && full)
        begin
            ovf_next = 1'b1;
        end
        if (m_accept && final_out)
        begin
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    // output side: head cell, or the empty marker when nothing was kept
    always_comb
    begin
        m_axis_tvalid = 1'b0;
        m_axis_tdata  = '0;
        m_axis_tuser  = '0;
        m_axis_tlast  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                m_axis_tvalid = 1'b0;
            end
            ST_DRAIN:
            begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = final_out;
                if (cnt_reg != '0)
                begin
                    m_axis_tdata[0]       = cell_q[0].is_dir;
                    m_axis_tdata[8:1]     = cell_q[0].kind;
                    m_axis_tdata[40:9]    = cell_q[0].size;
                    m_axis_tdata[104:41]  = cell_q[0].name_w0;
                    m_axis_tdata[168:105] = cell_q[0].name_w1;
                    m_axis_tdata[232:169] = cell_q[0].name_w2;
                    m_axis_tuser[1]       = ovf_reg;
                end
                else
                begin
                    m_axis_tuser[0] = 1'b1;
                end
            end
            default:
            begin
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire
